### src/crv_pkg.sv
// shared types, register indexes and the byte-wide crc update for the region verifier
`default_nettype none

package crv_pkg;

    // reflected crc-32 constants
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_CRC = 2'd0;
    localparam logic [1:0] CFG_COMPARE_MODE = 2'd1;
    localparam logic [1:0] CFG_LENGTH_LIMIT = 2'd2;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_MISMATCH = 2'd2
    } crv_status_t;

    // input request payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } crv_in_t;

    // result payload
    typedef struct packed {
        logic [31:0] crc_result;
        logic [15:0] length_seen;
        crv_status_t status;
    } crv_out_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [31:0] expected_crc;
        logic        compare_mode;
        logic [15:0] length_limit;
    } crv_cfg_t;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/crv_cfg_regs.sv
// configuration register file of the region verifier
`default_nettype none

module crv_cfg_regs #(
    parameter int MAX_REGION_BYTES = 49152
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_write,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    output crv_pkg::crv_cfg_t   cfg
);
    import crv_pkg::*;

    crv_cfg_t cfg_reg;

    // register writes, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_crc <= 32'd0;
            cfg_reg.compare_mode <= 1'b0;
            cfg_reg.length_limit <= 16'(MAX_REGION_BYTES);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EXPECTED_CRC: cfg_reg.expected_crc <= cfg_data;
                CFG_COMPARE_MODE: cfg_reg.compare_mode <= cfg_data[0];
                CFG_LENGTH_LIMIT: cfg_reg.length_limit <= cfg_data[15:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### src/crv_in_stage.sv
// input register stage: holds one request until the core takes it
`default_nettype none

module crv_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire crv_pkg::crv_in_t item,
    input  wire logic           advance,
    output logic                s1_valid,
    output crv_pkg::crv_in_t    s1_item
);
    import crv_pkg::*;

    logic    valid_reg;
    crv_in_t item_reg;
    logic    load;

    // refill whenever the stage is empty or drains this cycle
    assign item_stall = valid_reg && !advance;
    assign load       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (advance)
            valid_reg <= 1'b0;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item;
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

### src/crv_core.sv
// running crc and byte count, result forming and result register
`default_nettype none

module crv_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire crv_pkg::crv_cfg_t cfg,
    input  wire logic           s1_valid,
    input  wire crv_pkg::crv_in_t s1_item,
    output logic                advance,
    output logic                result_valid,
    input  wire logic           result_stall,
    output crv_pkg::crv_out_t   result
);
    import crv_pkg::*;

    logic [31:0] crc_reg;
    logic [15:0] count_reg;
    logic        overrun_reg;
    logic        res_valid_reg;
    crv_out_t    res_reg;

    logic [31:0] crc_next;
    logic [15:0] count_next;
    logic        overrun_next;
    logic [31:0] final_crc;
    crv_status_t status_next;
    logic        res_free;

    // a non-last request always moves; a last one needs the result register
    assign res_free = !res_valid_reg || !result_stall;
    assign advance  = s1_valid && (!s1_item.last || res_free);

    // per-byte update of crc and saturating count
    always_comb
    begin
        crc_next     = crc_reg;
        count_next   = count_reg;
        overrun_next = overrun_reg;
        if (s1_item.byte_present)
        begin
            crc_next = crc_byte(crc_reg, s1_item.data_byte);
            if (count_reg <= cfg.length_limit)
            begin
                if (count_reg == 16'hFFFF)
                    overrun_next = 1'b1;
                else
                    count_next = count_reg + 16'd1;
            end
        end
    end

    // status, length failure first
    assign final_crc = crc_next ^ CRC_ALL_ONES;

    always_comb
    begin
        if (overrun_next || (count_next > cfg.length_limit))
            status_next = STATUS_LENGTH;
        else if (cfg.compare_mode && (final_crc != cfg.expected_crc))
            status_next = STATUS_MISMATCH;
        else
            status_next = STATUS_OK;
    end

    // region state, cleared after the last request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_ALL_ONES;
            count_reg   <= 16'd0;
            overrun_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (s1_item.last)
            begin
                crc_reg     <= CRC_ALL_ONES;
                count_reg   <= 16'd0;
                overrun_reg <= 1'b0;
            end
            else
            begin
                crc_reg     <= crc_next;
                count_reg   <= count_next;
                overrun_reg <= overrun_next;
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && s1_item.last)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && s1_item.last)
        begin
            res_reg.crc_result  <= final_crc;
            res_reg.length_seen <= count_next;
            res_reg.status      <= status_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

### src/crc32_region_verifier.sv
// top level of the crc-32 region verifier
//
// Streams a region one byte per request and keeps a reflected CRC-32
// (poly 0xEDB88320, init and final xor all ones) plus a byte count that
// saturates one past length_limit. A request with last set closes the region
// and, once it has passed the input register, presents one result in the result
// register: the final CRC, the count and a status (0 ok, 1 length over limit,
// 2 CRC mismatch in compare mode; length wins when both fail). A last request
// with no byte closes an empty region (CRC 0). One request is taken every cycle
// while the input is not stalled; the byte update is one 8-step xor network
// between the input register and the state and result registers. Input stalls
// only when a last request waits on a result register that is full and stalled.
// The user must write configuration only while the block is idle; the block
// does not enforce this.
`default_nettype none

module crc32_region_verifier #(
    parameter int MAX_REGION_BYTES = 49152
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire crv_pkg::crv_in_t item,
    output logic                result_valid,
    input  wire logic           result_stall,
    output crv_pkg::crv_out_t   result,
    input  wire logic           cfg_write,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data
);
    import crv_pkg::*;

    crv_cfg_t cfg;
    logic     s1_valid;
    crv_in_t  s1_item;
    logic     advance;

    // configuration registers
    crv_cfg_regs #(
        .MAX_REGION_BYTES(MAX_REGION_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    crv_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    // crc datapath and result register
    crv_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .s1_valid     (s1_valid),
        .s1_item      (s1_item),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### src/crv_checker.sv
// port-level checks of the region verifier, bound to the top level
`default_nettype none

module crv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_stall,
    input wire crv_pkg::crv_in_t item,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire crv_pkg::crv_out_t result
);
    import crv_pkg::*;

    // a stalled request holds
    a_request_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled request changed");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // input only backs up behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with empty result register");

    // an empty region has a zero crc
    a_empty_crc: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.length_seen == 16'd0) |-> result.crc_result == 32'd0)
        else $error("empty region gave nonzero crc");

    // no new result without an accepted request or a stalled input behind it
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2) || $past(item_stall, 1))
        else $error("result with no request behind it");

endmodule

bind crc32_region_verifier crv_checker u_crv_checker (.*);

`default_nettype wire
